>>> design/rrpc_pkg.sv
// rrpc_pkg: shared types and constants for the rounded rectangle pixel classifier
// no dependencies; imported by every module of the block
package rrpc_pkg;

	localparam int unsigned MAX_COORD = 4096;

	localparam int unsigned PIX_W  = 12;
	localparam int unsigned REG_W  = 13;
	localparam int unsigned RAD_W  = 12;
	localparam int unsigned CW     = 16;
	localparam int unsigned SQ_W   = 2 * CW - 1;
	localparam int unsigned RR_W   = 2 * RAD_W;
	localparam int unsigned IDX_W  = 3;
	localparam int unsigned KIND_W = 2;

	localparam int unsigned CFG_LAT = 3;
	localparam int unsigned CNT_W   = $clog2(CFG_LAT + 1);

	localparam logic [IDX_W-1:0] REG_LEFT_X        = 3'd0;
	localparam logic [IDX_W-1:0] REG_TOP_Y         = 3'd1;
	localparam logic [IDX_W-1:0] REG_BOX_WIDTH     = 3'd2;
	localparam logic [IDX_W-1:0] REG_BOX_HEIGHT    = 3'd3;
	localparam logic [IDX_W-1:0] REG_CORNER_RADIUS = 3'd4;
	localparam logic [IDX_W-1:0] REG_OUTLINE_WIDTH = 3'd5;
	localparam logic [IDX_W-1:0] REG_FILL_ENABLE   = 3'd6;

	localparam logic [KIND_W-1:0] KIND_SKIP    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_OUTLINE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FILL    = 2'd2;

	typedef struct packed {
		logic signed [CW-1:0] x0;
		logic signed [CW-1:0] x1;
		logic signed [CW-1:0] y0;
		logic signed [CW-1:0] y1;
		logic signed [CW-1:0] xa;
		logic signed [CW-1:0] xb;
		logic signed [CW-1:0] ya;
		logic signed [CW-1:0] yb;
		logic [RR_W-1:0]      rr;
		logic                 empty;
	} shape_t;

	typedef struct packed {
		shape_t outer;
		shape_t inner;
		logic   fill;
		logic   outline_on;
		logic   busy;
	} cfg_t;

endpackage

>>> design/rounded_rect_pixel_classifier.sv
// rounded_rect_pixel_classifier: top level, input stage, two coverage lanes, output register
// depends on rrpc_pkg, rrpc_cfg and rrpc_lane
//
//   channel  direction  handshake                 payload
//   s_axis   in         s_axis_tvalid/tready      tdata: pixel_x, pixel_y
//   m_axis   out        m_axis_tvalid/tready      tdata: paint_kind
//   cfg      in         cfg_valid/cfg_ready       cfg_index, cfg_data
//
// one item per clock while s_axis_tready is high; each result passes through
// five register stages: input register, three lane stages, output register
// after reset and after each register write, s_axis_tready stays low while the
// derived box values settle
// a stalled output holds the whole pipeline; nothing is dropped or repeated
module rounded_rect_pixel_classifier
	import rrpc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [23:0]      s_axis_tdata,  // [11:0] pixel_x, [23:12] pixel_y
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [7:0]       m_axis_tdata,  // [1:0] paint_kind, rest zero
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0] cfg_data
);

	cfg_t                 cfg;
	logic                 en, take;
	logic                 v_s1, v_s2, v_s3, v_s4;
	logic                 far_s1, far_s2, far_s3, far_s4;
	logic signed [CW-1:0] px_s1, py_s1;
	logic                 cov_o, cov_i;
	logic [KIND_W-1:0]    kind;
	logic [KIND_W-1:0]    kind_q;
	logic [PIX_W-1:0]     pix_x, pix_y;

	rrpc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en && !cfg.busy;
	assign take          = s_axis_tvalid && s_axis_tready;
	assign pix_x         = s_axis_tdata[PIX_W-1:0];
	assign pix_y         = s_axis_tdata[2*PIX_W-1:PIX_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			v_s3          <= 1'b0;
			v_s4          <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			v_s1          <= take;
			v_s2          <= v_s1;
			v_s3          <= v_s2;
			v_s4          <= v_s3;
			m_axis_tvalid <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1  <= $signed(CW'(pix_x));
			py_s1  <= $signed(CW'(pix_y));
			far_s1 <= (32'(pix_x) >= MAX_COORD) || (32'(pix_y) >= MAX_COORD);
			far_s2 <= far_s1;
			far_s3 <= far_s2;
			far_s4 <= far_s3;
		end
	end

	rrpc_lane u_outer (
		.clk     (clk),
		.en      (en),
		.px      (px_s1),
		.py      (py_s1),
		.shape   (cfg.outer),
		.covered (cov_o)
	);

	rrpc_lane u_inner (
		.clk     (clk),
		.en      (en),
		.px      (px_s1),
		.py      (py_s1),
		.shape   (cfg.inner),
		.covered (cov_i)
	);

	always_comb begin
		kind = KIND_SKIP;
		if (!far_s4 && cov_o) begin
			if (cfg.outline_on && !cov_i)
				kind = KIND_OUTLINE;
			else if (cfg.fill)
				kind = KIND_FILL;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			kind_q <= kind;
	end

	assign m_axis_tdata = {{(8 - KIND_W){1'b0}}, kind_q};

endmodule

>>> design/rrpc_cfg.sv
// rrpc_cfg: configuration registers and the derived outer and inner shapes
// depends on rrpc_pkg
module rrpc_cfg
	import rrpc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [IDX_W-1:0]        cfg_index,
	input  logic [REG_W-1:0]        cfg_data,
	output cfg_t                    cfg
);

	logic signed [REG_W-1:0] left_q, top_q;
	logic [REG_W-1:0]        bw_q, bh_q;
	logic [RAD_W-1:0]        cr_q, ow_q;
	logic                    fill_q;
	logic [CNT_W-1:0]        settle_q;
	logic                    wr;

	// stage a
	logic signed [CW-1:0] x0_s1, x1_s1, y0_s1, y1_s1;
	logic [RAD_W-1:0]     rad_s1, ow_s1;
	logic                 empty_s1, iempty_s1;
	// stage b
	shape_t               outer_s2;
	logic signed [CW-1:0] x0i_s2, x1i_s2, y0i_s2, y1i_s2;
	logic [RAD_W-1:0]     radi_s2;
	logic                 iempty_s2;
	// stage c
	shape_t               outer_s3, inner_s3;

	logic [REG_W-1:0]     bwm1, bhm1;
	logic [RAD_W-1:0]     halfw, halfh, rad_c;
	logic signed [CW-1:0] x0_c, y0_c;

	assign wr        = cfg_valid && cfg_ready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			top_q    <= '0;
			bw_q     <= '0;
			bh_q     <= '0;
			cr_q     <= '0;
			ow_q     <= '0;
			fill_q   <= 1'b0;
			settle_q <= CNT_W'(CFG_LAT);
		end else begin
			if (wr) begin
				settle_q <= CNT_W'(CFG_LAT);
				case (cfg_index)
					REG_LEFT_X:        left_q <= $signed(cfg_data);
					REG_TOP_Y:         top_q  <= $signed(cfg_data);
					REG_BOX_WIDTH:     bw_q   <= cfg_data;
					REG_BOX_HEIGHT:    bh_q   <= cfg_data;
					REG_CORNER_RADIUS: cr_q   <= cfg_data[RAD_W-1:0];
					REG_OUTLINE_WIDTH: ow_q   <= cfg_data[RAD_W-1:0];
					REG_FILL_ENABLE:   fill_q <= cfg_data[0];
					default: ;
				endcase
			end else if (settle_q != '0) begin
				settle_q <= settle_q - CNT_W'(1);
			end
		end
	end

	// clamp radius to half of the inner extent on both axes
	always_comb begin
		bwm1  = bw_q - REG_W'(1);
		bhm1  = bh_q - REG_W'(1);
		halfw = bwm1[REG_W-1:1];
		halfh = bhm1[REG_W-1:1];
		rad_c = cr_q;
		if (halfw < rad_c)
			rad_c = halfw;
		if (halfh < rad_c)
			rad_c = halfh;
		x0_c = CW'(left_q);
		y0_c = CW'(top_q);
	end

	always_ff @(posedge clk) begin
		x0_s1     <= x0_c;
		y0_s1     <= y0_c;
		x1_s1     <= x0_c + $signed(CW'(bwm1));
		y1_s1     <= y0_c + $signed(CW'(bhm1));
		rad_s1    <= rad_c;
		ow_s1     <= ow_q;
		empty_s1  <= (bw_q == '0) || (bh_q == '0);
		iempty_s1 <= (bw_q <= {ow_q, 1'b0}) || (bh_q <= {ow_q, 1'b0});
	end

	always_ff @(posedge clk) begin
		outer_s2.x0    <= x0_s1;
		outer_s2.x1    <= x1_s1;
		outer_s2.y0    <= y0_s1;
		outer_s2.y1    <= y1_s1;
		outer_s2.xa    <= x0_s1 + $signed(CW'(rad_s1));
		outer_s2.xb    <= x1_s1 - $signed(CW'(rad_s1));
		outer_s2.ya    <= y0_s1 + $signed(CW'(rad_s1));
		outer_s2.yb    <= y1_s1 - $signed(CW'(rad_s1));
		outer_s2.rr    <= rad_s1 * rad_s1;
		outer_s2.empty <= empty_s1;
		x0i_s2         <= x0_s1 + $signed(CW'(ow_s1));
		x1i_s2         <= x1_s1 - $signed(CW'(ow_s1));
		y0i_s2         <= y0_s1 + $signed(CW'(ow_s1));
		y1i_s2         <= y1_s1 - $signed(CW'(ow_s1));
		radi_s2        <= (rad_s1 > ow_s1) ? rad_s1 - ow_s1 : '0;
		iempty_s2      <= empty_s1 || iempty_s1;
	end

	always_ff @(posedge clk) begin
		outer_s3       <= outer_s2;
		inner_s3.x0    <= x0i_s2;
		inner_s3.x1    <= x1i_s2;
		inner_s3.y0    <= y0i_s2;
		inner_s3.y1    <= y1i_s2;
		inner_s3.xa    <= x0i_s2 + $signed(CW'(radi_s2));
		inner_s3.xb    <= x1i_s2 - $signed(CW'(radi_s2));
		inner_s3.ya    <= y0i_s2 + $signed(CW'(radi_s2));
		inner_s3.yb    <= y1i_s2 - $signed(CW'(radi_s2));
		inner_s3.rr    <= radi_s2 * radi_s2;
		inner_s3.empty <= iempty_s2;
	end

	assign cfg.outer      = outer_s3;
	assign cfg.inner      = inner_s3;
	assign cfg.fill       = fill_q;
	assign cfg.outline_on = (ow_q != '0);
	assign cfg.busy       = (settle_q != '0);

endmodule

>>> design/rrpc_lane.sv
// rrpc_lane: three stage coverage test of one pixel against one rounded box
// depends on rrpc_pkg
module rrpc_lane
	import rrpc_pkg::*;
(
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [CW-1:0] px,
	input  logic signed [CW-1:0] py,
	input  shape_t               shape,
	output logic                 covered
);

	logic                 inx_s2, iny_s2, midx_s2, midy_s2;
	logic signed [CW-1:0] dx_s2, dy_s2;
	logic [SQ_W-1:0]      sqx_s3, sqy_s3;
	logic                 inbox_s3, mid_s3;
	logic                 cov_s4;

	logic signed [2*CW-1:0] prodx, prody;
	logic [SQ_W:0]          dsq;

	always_ff @(posedge clk) begin
		if (en) begin
			inx_s2  <= (px >= shape.x0) && (px <= shape.x1);
			iny_s2  <= (py >= shape.y0) && (py <= shape.y1);
			midx_s2 <= (px >= shape.xa) && (px <= shape.xb);
			midy_s2 <= (py >= shape.ya) && (py <= shape.yb);
			dx_s2   <= px - ((px < shape.xa) ? shape.xa : shape.xb);
			dy_s2   <= py - ((py < shape.ya) ? shape.ya : shape.yb);
		end
	end

	assign prodx = dx_s2 * dx_s2;
	assign prody = dy_s2 * dy_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s3   <= prodx[SQ_W-1:0];
			sqy_s3   <= prody[SQ_W-1:0];
			inbox_s3 <= inx_s2 && iny_s2;
			mid_s3   <= midx_s2 || midy_s2;
		end
	end

	assign dsq = {1'b0, sqx_s3} + {1'b0, sqy_s3};

	always_ff @(posedge clk) begin
		if (en)
			cov_s4 <= !shape.empty && inbox_s3 && (mid_s3 || (dsq <= (SQ_W + 1)'(shape.rr)));
	end

	assign covered = cov_s4;

endmodule

>>> dv/tb_rounded_rect_pixel_classifier.sv
// tb_rounded_rect_pixel_classifier: self-checking bench that streams pixels through the
// rounded rectangle classifier and checks each paint kind against a behavioural prediction
// depends on rrpc_pkg and rounded_rect_pixel_classifier
`timescale 1ns / 1ps

module tb_rounded_rect_pixel_classifier;
	import rrpc_pkg::*;

	localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int unsigned HOLD_CYCLES    = 300;
	localparam int unsigned SETTLE_CYCLES  = 8;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned ITEM_TARGET    = 1150;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [23:0]      s_axis_tdata = '0;  // [11:0] pixel_x, [23:12] pixel_y
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [7:0]       m_axis_tdata;       // [1:0] paint_kind, rest zero
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [REG_W-1:0] cfg_data = '0;

	// register shadow used by the prediction
	logic signed [REG_W-1:0] box_left = '0;
	logic signed [REG_W-1:0] box_top = '0;
	logic [REG_W-1:0]        box_w = '0;
	logic [REG_W-1:0]        box_h = '0;
	logic [RAD_W-1:0]        radius_req = '0;
	logic [RAD_W-1:0]        outline_w = '0;
	logic                    fill_on = 1'b0;

	logic [KIND_W-1:0] pending_kinds[$];
	logic [KIND_W-1:0] kind_exp;
	int unsigned err_count = 0;
	int unsigned items_sent = 0;
	int unsigned send_idle_pct = 33;
	int unsigned recv_idle_pct = 33;
	int unsigned hold_requests = 0;
	int unsigned hold_served = 0;
	int unsigned hold_left = 0;
	int unsigned quiet_cycles = 0;

	rounded_rect_pixel_classifier i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic bit in_rounded_box(longint px, longint py, longint x0, longint y0,
		longint x1, longint y1, longint rad, longint shrink);
		longint ax0, ay0, ax1, ay1, r, cx, cy, dx, dy;
		ax0 = x0 + shrink;
		ay0 = y0 + shrink;
		ax1 = x1 - shrink;
		ay1 = y1 - shrink;
		if (ax0 > ax1 || ay0 > ay1)
			return 1'b0;
		r = rad - shrink;
		if (r < 0)
			r = 0;
		if (px < ax0 || px > ax1 || py < ay0 || py > ay1)
			return 1'b0;
		if (r == 0)
			return 1'b1;
		if ((px >= ax0 + r && px <= ax1 - r) || (py >= ay0 + r && py <= ay1 - r))
			return 1'b1;
		cx = (px < ax0 + r) ? ax0 + r : ax1 - r;
		cy = (py < ay0 + r) ? ay0 + r : ay1 - r;
		dx = px - cx;
		dy = py - cy;
		return (dx * dx + dy * dy) <= r * r;
	endfunction

	function automatic logic [KIND_W-1:0] classify_pixel(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y);
		longint px, py, x0, y0, x1, y1, rad;
		px = x;
		py = y;
		if (px >= MAX_COORD || py >= MAX_COORD || box_w == 0 || box_h == 0)
			return KIND_SKIP;
		x0 = box_left;
		y0 = box_top;
		x1 = x0 + longint'(box_w) - 1;
		y1 = y0 + longint'(box_h) - 1;
		rad = radius_req;
		if ((x1 - x0) / 2 < rad)
			rad = (x1 - x0) / 2;
		if ((y1 - y0) / 2 < rad)
			rad = (y1 - y0) / 2;
		if (!in_rounded_box(px, py, x0, y0, x1, y1, rad, 0))
			return KIND_SKIP;
		if (outline_w != 0 && !in_rounded_box(px, py, x0, y0, x1, y1, rad, longint'(outline_w)))
			return KIND_OUTLINE;
		return fill_on ? KIND_FILL : KIND_SKIP;
	endfunction

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
			if (pending_kinds.size() == 0) begin
				$error("paint_kind: no result expected, got %0d", m_axis_tdata[1:0]);
				err_count++;
			end else begin
				kind_exp = pending_kinds.pop_front();
				if (m_axis_tdata[1:0] !== kind_exp) begin
					$error("paint_kind: expected %0d, got %0d", kind_exp, m_axis_tdata[1:0]);
					err_count++;
				end
			end
		end
	end

	// receiver with random stalls and on-request long hold-off
	always @(posedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_pixel(input int x, input int y);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {PIX_W'(y), PIX_W'(x)};
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		pending_kinds.push_back(classify_pixel(PIX_W'(x), PIX_W'(y)));
		items_sent++;
	endtask

	task automatic wait_all_results();
		s_axis_tvalid <= 1'b0;
		while (pending_kinds.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			REG_LEFT_X:        box_left = data;
			REG_TOP_Y:         box_top = data;
			REG_BOX_WIDTH:     box_w = data;
			REG_BOX_HEIGHT:    box_h = data;
			REG_CORNER_RADIUS: radius_req = data[RAD_W-1:0];
			REG_OUTLINE_WIDTH: outline_w = data[RAD_W-1:0];
			REG_FILL_ENABLE:   fill_on = data[0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_box(input int left, input int top, input int w, input int h,
		input int rad, input int ol, input int fill);
		wait_all_results();
		write_reg(REG_LEFT_X, REG_W'(left));
		write_reg(REG_TOP_Y, REG_W'(top));
		write_reg(REG_BOX_WIDTH, REG_W'(w));
		write_reg(REG_BOX_HEIGHT, REG_W'(h));
		write_reg(REG_CORNER_RADIUS, REG_W'(rad));
		write_reg(REG_OUTLINE_WIDTH, REG_W'(ol));
		write_reg(REG_FILL_ENABLE, REG_W'(fill));
	endtask

	task automatic send_near_box();
		int lo_x, lo_y, px, py;
		if ($urandom_range(7) == 0) begin
			send_pixel($urandom_range(4095), $urandom_range(4095));
		end else begin
			lo_x = int'(box_left) - 3;
			lo_y = int'(box_top) - 3;
			px = lo_x + int'($urandom_range(int'(box_w) + 5));
			py = lo_y + int'($urandom_range(int'(box_h) + 5));
			px = (px < 0) ? 0 : (px > 4095) ? 4095 : px;
			py = (py < 0) ? 0 : (py > 4095) ? 4095 : py;
			send_pixel(px, py);
		end
	endtask

	task automatic test_reset_state();
		send_pixel(0, 0);
		send_pixel(4095, 4095);
	endtask

	task automatic test_empty_box();
		set_box(0, 0, 0, 10, 2, 1, 1);
		send_pixel(0, 0);
		set_box(0, 0, 10, 0, 2, 1, 1);
		send_pixel(0, 0);
	endtask

	task automatic test_corner_arcs();
		set_box(10, 20, 21, 15, 6, 2, 1);
		send_pixel(10, 20);
		send_pixel(12, 22);
		send_pixel(11, 24);
		send_pixel(20, 27);
		send_pixel(20, 21);
		send_pixel(31, 20);
	endtask

	task automatic test_radius_clamp();
		set_box(100, 100, 9, 30, 2048, 1, 1);
		send_pixel(100, 100);
		send_pixel(101, 103);
	endtask

	task automatic test_outline_swallows_box();
		set_box(50, 60, 6, 6, 0, 3, 1);
		send_pixel(52, 62);
		send_pixel(55, 65);
	endtask

	task automatic test_field_extremes();
		set_box(-4096, -4096, 8191, 8191, 4095, 4095, 1);
		send_pixel(0, 0);
		send_pixel(4095, 4095);
		send_pixel(4095, 0);
		send_pixel(0, 4095);
		set_box(4095, 4095, 1, 1, 0, 0, 1);
		send_pixel(4095, 4095);
		send_pixel(4094, 4095);
	endtask

	task automatic test_unknown_register();
		wait_all_results();
		write_reg(REG_UNUSED, 13'h1FFF);
		send_pixel(4095, 4095);
	endtask

	task automatic test_output_backpressure();
		set_box(200, 300, 40, 25, 8, 3, 1);
		send_idle_pct = 0;
		hold_requests++;
		repeat (60) send_near_box();
		wait_all_results();
		send_idle_pct = 33;
	endtask

	task automatic test_random_boxes();
		int unsigned phase, n, w, h;
		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			if ($urandom_range(9) == 0) begin
				set_box($urandom_range(8191), $urandom_range(8191), $urandom_range(8191),
					$urandom_range(8191), $urandom_range(8191), $urandom_range(8191),
					$urandom_range(8191));
			end else begin
				w = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 80);
				h = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 80);
				set_box(int'($urandom_range(4145)) - 50 > 4095 ? 4095 : int'($urandom_range(4145)) - 50,
					int'($urandom_range(4145)) - 50 > 4095 ? 4095 : int'($urandom_range(4145)) - 50,
					w, h,
					($urandom_range(9) == 0) ? 4095 : $urandom_range(45),
					($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12),
					$urandom_range(1));
			end
			if (phase == 3 || $urandom_range(4) == 0) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else begin
				send_idle_pct = 33;
				recv_idle_pct = 33;
			end
			n = (phase == 3) ? 150 : $urandom_range(20, 80);
			repeat (n) send_near_box();
			phase++;
		end
		send_idle_pct = 33;
		recv_idle_pct = 33;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_empty_box();
		test_corner_arcs();
		test_radius_clamp();
		test_outline_swallows_box();
		test_field_extremes();
		test_unknown_register();
		test_output_backpressure();
		test_random_boxes();
		wait_all_results();
		if (pending_kinds.size() != 0)
			$error("paint_kind: %0d results never arrived", pending_kinds.size());
		if (err_count == 0 && pending_kinds.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

>>> filelist.f
design/rrpc_pkg.sv
design/rrpc_cfg.sv
design/rrpc_lane.sv
design/rounded_rect_pixel_classifier.sv
dv/tb_rounded_rect_pixel_classifier.sv
